>>> rtl/core/vec3au_pkg.sv
// Shared types and constants for the three-component vector arithmetic unit.
package vec3au_pkg;

  localparam int COMP_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_DOT,
    OP_CROSS,
    OP_MAG,
    OP_MAGSQ,
    OP_NORM
  } op_t;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [COMP_WIDTH-1:0] ax;
    logic signed [COMP_WIDTH-1:0] ay;
    logic signed [COMP_WIDTH-1:0] az;
    logic signed [COMP_WIDTH-1:0] bx;
    logic signed [COMP_WIDTH-1:0] by_comp;
    logic signed [COMP_WIDTH-1:0] bz;
    logic signed [COMP_WIDTH-1:0] factor;
  } req_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] rx;
    logic signed [COMP_WIDTH-1:0] ry;
    logic signed [COMP_WIDTH-1:0] rz;
    logic signed [COMP_WIDTH-1:0] scalar_out;
    logic                         overflow;
  } rsp_t;

  // Per-transaction control carried alongside the root and quotient pipelines
  typedef struct packed {
    logic       is_mag;
    logic       is_norm;
    logic       nz;
    logic [2:0] neg;
  } flags_t;

endpackage

>>> rtl/core/vec3au_prod.sv
// Front end: operand select and multipliers, product combine, round and saturate.
module vec3au_prod #(
  parameter int FRAC_BITS = vec3au_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  vec3au_pkg::req_t                      req,
  output logic                                  out_valid,
  output vec3au_pkg::rsp_t                      res,
  output vec3au_pkg::flags_t                    flags,
  output logic [2*vec3au_pkg::COMP_WIDTH-1:0]   ss,
  output logic [3*vec3au_pkg::COMP_WIDTH-1:0]   amag
);

  localparam int W  = vec3au_pkg::COMP_WIDTH;
  localparam int PW = 2*W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [PW-1:0] ext(input logic signed [2*W-1:0] p);
    return {{2{p[2*W-1]}}, p};
  endfunction

  // Round half up at the binary point, then clamp; returns {ov, value}
  function automatic logic [W:0] sat_prod(input logic signed [PW-1:0] e);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] sh;
    logic [PW-W:0]        top;
    r   = e + HALF;
    sh  = r >>> FRAC_BITS;
    top = sh[PW-1:W-1];
    if ((&top) || (~|top)) return {1'b0, sh[W-1:0]};
    return {1'b1, (sh[PW-1] ? MINV : MAXV)};
  endfunction

  function automatic logic [W:0] sat_sum(input logic [W:0] s);
    if (s[W] == s[W-1]) return {1'b0, s[W-1:0]};
    return {1'b1, (s[W] ? MINV : MAXV)};
  endfunction

  vec3au_pkg::op_t op_in;
  logic signed [W-1:0]   mx [6];
  logic signed [W-1:0]   my [6];
  logic signed [2*W-1:0] prod_c [6];
  logic [W:0]            sum_c [3];
  logic [W-1:0]          a_c [3];
  logic [W-1:0]          b_c [3];
  logic [3*W-1:0]        mag_c;

  // stage 1
  logic                  v1;
  vec3au_pkg::op_t       op1;
  logic signed [2*W-1:0] p1 [6];
  logic [W:0]            s1 [3];
  logic [3*W-1:0]        mag1;
  logic [2:0]            neg1;

  // stage 2
  logic                  v2;
  vec3au_pkg::op_t       op2;
  logic signed [PW-1:0]  e2 [3];
  logic signed [PW-1:0]  e_c [3];
  logic [W:0]            s2 [3];
  logic [3*W-1:0]        mag2;
  logic [2:0]            neg2;

  logic [W:0]            rp [3];
  logic [W:0]            rs [3];
  vec3au_pkg::rsp_t      res_c;
  vec3au_pkg::flags_t    flags_c;

  assign op_in = vec3au_pkg::op_t'(req.opcode);
  assign a_c[0] = req.ax;
  assign a_c[1] = req.ay;
  assign a_c[2] = req.az;
  assign b_c[0] = req.bx;
  assign b_c[1] = req.by_comp;
  assign b_c[2] = req.bz;

  always_comb begin
    mx[0] = req.ax;  my[0] = req.ax;
    mx[1] = req.ay;  my[1] = req.ay;
    mx[2] = req.az;  my[2] = req.az;
    mx[3] = req.ax;  my[3] = req.bz;
    mx[4] = req.ax;  my[4] = req.by_comp;
    mx[5] = req.ay;  my[5] = req.bx;
    case (op_in)
      vec3au_pkg::OP_SCALE: begin
        my[0] = req.factor;
        my[1] = req.factor;
        my[2] = req.factor;
      end
      vec3au_pkg::OP_DOT: begin
        my[0] = req.bx;
        my[1] = req.by_comp;
        my[2] = req.bz;
      end
      vec3au_pkg::OP_CROSS: begin
        mx[0] = req.ay;  my[0] = req.bz;
        mx[1] = req.az;  my[1] = req.by_comp;
        mx[2] = req.az;  my[2] = req.bx;
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) begin
      prod_c[i] = mx[i] * my[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (op_in == vec3au_pkg::OP_SUB) begin
        sum_c[i] = {a_c[i][W-1], a_c[i]} - {b_c[i][W-1], b_c[i]};
      end else begin
        sum_c[i] = {a_c[i][W-1], a_c[i]} + {b_c[i][W-1], b_c[i]};
      end
      mag_c[i*W +: W] = a_c[i][W-1] ? (~a_c[i] + 1'b1) : a_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op_in;
      p1   <= prod_c;
      s1   <= sum_c;
      mag1 <= mag_c;
      neg1 <= {req.az[W-1], req.ay[W-1], req.ax[W-1]};
    end
  end

  // Combine products: scale passes through, cross subtracts, dot and norms sum
  always_comb begin
    case (op1)
      vec3au_pkg::OP_SCALE: begin
        e_c[0] = ext(p1[0]);
        e_c[1] = ext(p1[1]);
        e_c[2] = ext(p1[2]);
      end
      vec3au_pkg::OP_CROSS: begin
        e_c[0] = ext(p1[0]) - ext(p1[1]);
        e_c[1] = ext(p1[2]) - ext(p1[3]);
        e_c[2] = ext(p1[4]) - ext(p1[5]);
      end
      default: begin
        e_c[0] = ext(p1[0]) + ext(p1[1]) + ext(p1[2]);
        e_c[1] = ext(p1[1]);
        e_c[2] = ext(p1[2]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2  <= op1;
      e2   <= e_c;
      s2   <= s1;
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rp[i] = sat_prod(e2[i]);
      rs[i] = sat_sum(s2[i]);
    end
    res_c = '0;
    case (op2)
      vec3au_pkg::OP_ADD, vec3au_pkg::OP_SUB: begin
        res_c.rx = rs[0][W-1:0];
        res_c.ry = rs[1][W-1:0];
        res_c.rz = rs[2][W-1:0];
        res_c.overflow = rs[0][W] | rs[1][W] | rs[2][W];
      end
      vec3au_pkg::OP_SCALE, vec3au_pkg::OP_CROSS: begin
        res_c.rx = rp[0][W-1:0];
        res_c.ry = rp[1][W-1:0];
        res_c.rz = rp[2][W-1:0];
        res_c.overflow = rp[0][W] | rp[1][W] | rp[2][W];
      end
      vec3au_pkg::OP_DOT, vec3au_pkg::OP_MAGSQ: begin
        res_c.scalar_out = rp[0][W-1:0];
        res_c.overflow = rp[0][W];
      end
      default: ;
    endcase
    flags_c.is_mag  = (op2 == vec3au_pkg::OP_MAG);
    flags_c.is_norm = (op2 == vec3au_pkg::OP_NORM);
    flags_c.nz      = |e2[0][2*W-1:0];
    flags_c.neg     = neg2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res   <= res_c;
      flags <= flags_c;
      ss    <= e2[0][2*W-1:0];
      amag  <= mag2;
    end
  end

endmodule

>>> rtl/core/vec3au_sqrt.sv
// Pipelined square root, one root bit per stage, rounded to nearest at the end.
module vec3au_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2*vec3au_pkg::COMP_WIDTH-1:0] ss,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                out_valid,
  output logic [vec3au_pkg::COMP_WIDTH-1:0]   root,
  output logic [SIDE_W-1:0]                   side_out
);

  localparam int W = vec3au_pkg::COMP_WIDTH;

  logic              v_q    [W];
  logic [W+1:0]      rem_q  [W];
  logic [W-1:0]      root_q [W];
  logic [2*W-1:0]    ss_q   [W];
  logic [SIDE_W-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic              v_p;
    logic [W+1:0]      rem_p;
    logic [W-1:0]      root_p;
    logic [2*W-1:0]    ss_p;
    logic [SIDE_W-1:0] side_p;
    logic [W+1:0]      rem_sh;
    logic [W+1:0]      trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign ss_p   = ss;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = v_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign ss_p   = ss_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down the next two radicand bits and try root bit one
    assign rem_sh = {rem_p[W-1:0], ss_p[2*(W-1-k)+1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[W-2:0], ge};
        ss_q[k]   <= ss_p;
        side_q[k] <= side_p;
      end
    end
  end

  // Round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root     <= root_q[W-1] + W'(rem_q[W-1] > {2'b00, root_q[W-1]});
      side_out <= side_q[W-1];
    end
  end

endmodule

>>> rtl/core/vec3au_div.sv
// Three-lane pipelined restoring divider for the normalise quotients.
module vec3au_div #(
  parameter int FRAC_BITS = vec3au_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [vec3au_pkg::COMP_WIDTH-1:0]   m,
  input  logic [3*vec3au_pkg::COMP_WIDTH-1:0] amag,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                out_valid,
  output logic [3*(FRAC_BITS+1)-1:0]          quo,
  output logic [SIDE_W-1:0]                   side_out
);

  localparam int W  = vec3au_pkg::COMP_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  logic              v0;
  logic [W-1:0]      d0;
  logic [NW-1:0]     num0 [3];
  logic [SIDE_W-1:0] side0;

  logic              v_q    [QW];
  logic [W-1:0]      d_q    [QW];
  logic [SIDE_W-1:0] side_q [QW];
  logic [W-1:0]      rem_q  [QW][3];
  logic [QW-1:0]     q_q    [QW][3];
  logic [NW-1:0]     num_q  [QW][3];

  // Numerator is |a| at the binary point plus half the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0    <= m;
      side0 <= side_in;
      for (int l = 0; l < 3; l++) begin
        num0[l] <= {amag[l*W +: W], {FRAC_BITS{1'b0}}} + NW'(m >> 1);
      end
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_step
    logic              v_p;
    logic [W-1:0]      d_p;
    logic [SIDE_W-1:0] side_p;
    logic [W-1:0]      rem_p [3];
    logic [QW-1:0]     q_p   [3];
    logic [NW-1:0]     num_p [3];
    logic [W:0]        rem_sh [3];
    logic [W-1:0]      rem_n [3];
    logic [QW-1:0]     q_n   [3];

    if (t == 0) begin : g_first
      assign v_p    = v0;
      assign d_p    = d0;
      assign side_p = side0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l] = {1'b0, num0[l][NW-1:QW]};
        assign q_p[l]   = '0;
        assign num_p[l] = num0[l];
      end
    end else begin : g_next
      assign v_p    = v_q[t-1];
      assign d_p    = d_q[t-1];
      assign side_p = side_q[t-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_p[l] = rem_q[t-1][l];
        assign q_p[l]   = q_q[t-1][l];
        assign num_p[l] = num_q[t-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_sh[l] = {rem_p[l], num_p[l][FRAC_BITS-t]};
        if (rem_sh[l] >= {1'b0, d_p}) begin
          rem_n[l] = W'(rem_sh[l] - {1'b0, d_p});
          q_n[l]   = {q_p[l][QW-2:0], 1'b1};
        end else begin
          rem_n[l] = rem_sh[l][W-1:0];
          q_n[l]   = {q_p[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[t] <= 1'b0;
      end else if (en) begin
        v_q[t] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[t]    <= d_p;
        side_q[t] <= side_p;
        for (int l = 0; l < 3; l++) begin
          rem_q[t][l] <= rem_n[l];
          q_q[t][l]   <= q_n[l];
          num_q[t][l] <= num_p[l];
        end
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign side_out  = side_q[QW-1];
  assign quo       = {q_q[QW-1][2], q_q[QW-1][1], q_q[QW-1][0]};

endmodule

>>> rtl/core/vec3_arithmetic_unit.sv
// Every opcode takes the same path: front end, square root, divider, output register.
// Throughput: one transaction per cycle unless stalled; the square root retires one root
// bit per stage, the divider one quotient bit per stage; those pipelines set the depth.
// Reset clears the valid bits of every stage and of the output and skid registers;
// data registers are not reset.
module vec3_arithmetic_unit #(
  parameter int FRAC_BITS = vec3au_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  vec3au_pkg::req_t req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output vec3au_pkg::rsp_t rsp
);

  localparam int W         = vec3au_pkg::COMP_WIDTH;
  localparam int QW        = FRAC_BITS + 1;
  localparam int RSP_W     = $bits(vec3au_pkg::rsp_t);
  localparam int FLAGS_W   = $bits(vec3au_pkg::flags_t);
  localparam int SQ_SIDE_W = RSP_W + FLAGS_W + 3*W;
  localparam int DV_SIDE_W = RSP_W + 1 + 3;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic en;

  logic                 pr_valid;
  vec3au_pkg::rsp_t     pr_res;
  vec3au_pkg::flags_t   pr_flags;
  logic [2*W-1:0]       pr_ss;
  logic [3*W-1:0]       pr_mag;

  logic                 sq_valid;
  logic [W-1:0]         sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  vec3au_pkg::rsp_t     sq_res;
  vec3au_pkg::flags_t   sq_flags;
  logic [3*W-1:0]       sq_mag;
  vec3au_pkg::rsp_t     mg_res;

  logic                 dv_valid;
  logic [3*QW-1:0]      dv_quo;
  logic [DV_SIDE_W-1:0] dv_side;
  vec3au_pkg::rsp_t     dv_res;
  logic                 dv_norm;
  logic [2:0]           dv_neg;
  logic [W-1:0]         qext [3];
  vec3au_pkg::rsp_t     fin_res;

  logic                 skid_valid;
  vec3au_pkg::rsp_t     skid;
  logic                 pop;
  logic                 pin;

  // The whole pipeline holds while a transaction sits in the skid register
  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  vec3au_prod #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prod (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .req       (req),
    .out_valid (pr_valid),
    .res       (pr_res),
    .flags     (pr_flags),
    .ss        (pr_ss),
    .amag      (pr_mag)
  );

  vec3au_sqrt #(
    .SIDE_W (SQ_SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_valid),
    .ss        (pr_ss),
    .side_in   ({pr_res, pr_flags, pr_mag}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {sq_res, sq_flags, sq_mag} = sq_side;

  // Magnitude result is formed here; clamp the unsigned root to the signed range
  always_comb begin
    mg_res = sq_res;
    if (sq_flags.is_mag) begin
      mg_res.scalar_out = sq_root[W-1] ? MAXV : sq_root;
      mg_res.overflow   = sq_root[W-1];
    end
  end

  vec3au_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (DV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .m         (sq_root),
    .amag      (sq_mag),
    .side_in   ({mg_res, sq_flags.is_norm & sq_flags.nz, sq_flags.neg}),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (dv_side)
  );

  assign {dv_res, dv_norm, dv_neg} = dv_side;

  // Restore the sign of each normalised component
  always_comb begin
    fin_res = dv_res;
    for (int l = 0; l < 3; l++) begin
      qext[l] = {{(W-QW){1'b0}}, dv_quo[l*QW +: QW]};
      if (dv_neg[l]) begin
        qext[l] = ~qext[l] + 1'b1;
      end
    end
    if (dv_norm) begin
      fin_res.rx = qext[0];
      fin_res.ry = qext[1];
      fin_res.rz = qext[2];
    end
  end

  assign pop = rsp_valid && !rsp_stall;
  assign pin = dv_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || pop) begin
      rsp_valid  <= skid_valid || pin;
      skid_valid <= 1'b0;
      rsp        <= skid_valid ? skid : fin_res;
    end else if (pin) begin
      skid_valid <= 1'b1;
      skid       <= fin_res;
    end
  end

  a_skid_has_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid register holds a transaction while the output is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(rsp_valid && rsp_stall))
    else $error("skid register filled without a stalled output");

  a_norm_quo_range: assert property (@(posedge clk) disable iff (rst)
    (dv_valid && dv_norm) |-> (!dv_quo[QW-1] || (dv_quo[QW-2:0] == '0)))
    else $error("normalise quotient exceeds one");

endmodule

>>> verif/vec3_arithmetic_unit_test.sv
// Self-checking testbench for the three-component vector arithmetic unit.
module vec3_arithmetic_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [vec3au_pkg::COMP_WIDTH-1:0] comp_t;

  localparam int    FRAC       = vec3au_pkg::FRAC_BITS_DEF;
  localparam int    IDLE_LIMIT = 2000;
  localparam comp_t COMP_MAX   = {1'b0, {(vec3au_pkg::COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN   = {1'b1, {(vec3au_pkg::COMP_WIDTH-1){1'b0}}};
  localparam comp_t ONE        = comp_t'(1) <<< FRAC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  vec3au_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  vec3au_pkg::rsp_t rsp;

  vec3au_pkg::req_t pending_reqs[$];
  int               pending_gaps[$];
  vec3au_pkg::rsp_t expected_rsps[$];
  int   errors = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   rsp_count = 0;

  vec3_arithmetic_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact fixed-point arithmetic at a width that never wraps
  function automatic wide_t widen(comp_t x);
    wide_t w;
    w = x;
    return w;
  endfunction

  function automatic wide_t round_frac(wide_t x);
    return (x + wide_t'(1 << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic comp_t clamp(wide_t x, inout logic ov);
    if (x > widen(COMP_MAX)) begin
      ov = 1'b1;
      return COMP_MAX;
    end
    if (x < widen(COMP_MIN)) begin
      ov = 1'b1;
      return COMP_MIN;
    end
    return comp_t'(x);
  endfunction

  function automatic wide_t root_nearest(wide_t s);
    logic [127:0] us;
    logic [63:0]  r;
    logic [63:0]  t;
    us = s;
    r  = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= us) r = t;
    end
    if (us - 128'(r) * 128'(r) > 128'(r)) r = r + 64'd1;
    return wide_t'({64'd0, r});
  endfunction

  // Divide by the length, rounding half away from zero
  function automatic wide_t unit_comp(wide_t a, wide_t m);
    logic [127:0] mag;
    logic [127:0] num;
    logic [127:0] um;
    wide_t        q;
    mag = (a < 0) ? -a : a;
    um  = m;
    num = (mag << FRAC) + (um >> 1);
    q   = num / um;
    return (a < 0) ? -q : q;
  endfunction

  function automatic vec3au_pkg::rsp_t predict_result(vec3au_pkg::req_t r);
    wide_t a[3];
    wide_t b[3];
    wide_t f;
    wide_t ss;
    wide_t m;
    comp_t v[3];
    comp_t s;
    logic  ov;
    vec3au_pkg::rsp_t res;
    a[0] = widen(r.ax); a[1] = widen(r.ay); a[2] = widen(r.az);
    b[0] = widen(r.bx); b[1] = widen(r.by_comp); b[2] = widen(r.bz);
    f  = widen(r.factor);
    ss = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    v  = '{default: '0};
    s  = '0;
    ov = 1'b0;
    case (vec3au_pkg::op_t'(r.opcode))
      vec3au_pkg::OP_ADD:
        for (int i = 0; i < 3; i++) v[i] = clamp(a[i] + b[i], ov);
      vec3au_pkg::OP_SUB:
        for (int i = 0; i < 3; i++) v[i] = clamp(a[i] - b[i], ov);
      vec3au_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) v[i] = clamp(round_frac(a[i] * f), ov);
      vec3au_pkg::OP_DOT:
        s = clamp(round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), ov);
      vec3au_pkg::OP_CROSS: begin
        v[0] = clamp(round_frac(a[1] * b[2] - a[2] * b[1]), ov);
        v[1] = clamp(round_frac(a[2] * b[0] - a[0] * b[2]), ov);
        v[2] = clamp(round_frac(a[0] * b[1] - a[1] * b[0]), ov);
      end
      vec3au_pkg::OP_MAG:   s = clamp(root_nearest(ss), ov);
      vec3au_pkg::OP_MAGSQ: s = clamp(round_frac(ss), ov);
      default: begin
        // zero-length vector normalises to zero without overflow
        if (ss != 0) begin
          m = root_nearest(ss);
          for (int i = 0; i < 3; i++) v[i] = clamp(unit_comp(a[i], m), ov);
        end
      end
    endcase
    res.rx = v[0]; res.ry = v[1]; res.rz = v[2];
    res.scalar_out = s;
    res.overflow   = ov;
    return res;
  endfunction

  function automatic comp_t random_comp();
    case ($urandom_range(0, 5))
      0, 1: return comp_t'($urandom);
      2: return comp_t'($urandom_range(0, 8 << FRAC)) - comp_t'(4 << FRAC);
      3: return comp_t'($urandom_range(0, 1 << 24)) - comp_t'(1 << 23);
      4: return comp_t'($urandom_range(0, 1 << 30)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      default: begin
        case ($urandom_range(0, 5))
          0: return COMP_MAX;
          1: return COMP_MIN;
          2: return '0;
          3: return comp_t'(1);
          4: return -comp_t'(1);
          default: return ONE;
        endcase
      end
    endcase
  endfunction

  task automatic queue_req(vec3au_pkg::op_t op, comp_t ax, comp_t ay, comp_t az,
                           comp_t bx, comp_t by, comp_t bz, comp_t fac);
    vec3au_pkg::req_t r;
    int   n;
    r.opcode = op;
    r.ax = ax; r.ay = ay; r.az = az;
    r.bx = bx; r.by_comp = by; r.bz = bz;
    r.factor = fac;
    n = pending_reqs.size();
    pending_reqs.push_back(r);
    // every third block of 64 transactions runs back to back
    pending_gaps.push_back(((n / 64) % 3 == 1) ? 0 : $urandom_range(0, 10));
  endtask

  // Driver: hold a payload until it is taken, then wait out its gap
  always @(posedge clk) begin
    logic nxt_valid;
    int   nxt_gap;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      nxt_valid = req_valid;
      nxt_gap   = gap_left;
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_result(req));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (pending_reqs.size() != 0) begin
          req       <= pending_reqs.pop_front();
          nxt_gap   = pending_gaps.pop_front();
          nxt_valid = 1'b1;
        end
      end
      req_valid <= nxt_valid;
      gap_left  <= nxt_gap;
    end
  end

  // Monitor: check each result transaction against the oldest prediction and drive the output stall
  always @(posedge clk) begin
    int   n;
    vec3au_pkg::rsp_t exp_rsp;
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      n = stall_left;
      if (rsp_valid && !rsp_stall) begin
        rsp_count <= rsp_count + 1;
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.rx !== exp_rsp.rx) begin
            $error("rx: expected %0d, got %0d", exp_rsp.rx, rsp.rx);
            errors++;
          end
          if (rsp.ry !== exp_rsp.ry) begin
            $error("ry: expected %0d, got %0d", exp_rsp.ry, rsp.ry);
            errors++;
          end
          if (rsp.rz !== exp_rsp.rz) begin
            $error("rz: expected %0d, got %0d", exp_rsp.rz, rsp.rz);
            errors++;
          end
          if (rsp.scalar_out !== exp_rsp.scalar_out) begin
            $error("scalar_out: expected %0d, got %0d", exp_rsp.scalar_out, rsp.scalar_out);
            errors++;
          end
          if (rsp.overflow !== exp_rsp.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_rsp.overflow, rsp.overflow);
            errors++;
          end
        end
        n = ((rsp_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        n--;
      end else begin
        rsp_stall <= 1'b0;
      end
      stall_left <= n;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("vec3_arithmetic_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    vec3au_pkg::op_t op;
    // extremes, every operation, zero-length normalise
    queue_req(vec3au_pkg::OP_ADD, COMP_MAX, COMP_MIN, '0, COMP_MAX, COMP_MIN, '0, '0);
    queue_req(vec3au_pkg::OP_ADD, ONE, -ONE, COMP_MAX, -ONE, ONE, COMP_MIN, '0);
    queue_req(vec3au_pkg::OP_SUB, COMP_MAX, COMP_MIN, ONE, COMP_MIN, COMP_MAX, ONE, '0);
    queue_req(vec3au_pkg::OP_SUB, '0, '0, '0, COMP_MIN, COMP_MIN, COMP_MIN, '0);
    queue_req(vec3au_pkg::OP_SCALE, COMP_MAX, COMP_MIN, ONE, '0, '0, '0, COMP_MAX);
    queue_req(vec3au_pkg::OP_SCALE, COMP_MIN, COMP_MAX, -ONE, '0, '0, '0, COMP_MIN);
    queue_req(vec3au_pkg::OP_SCALE, comp_t'(1), -comp_t'(1), comp_t'(3), '0, '0, '0,
              ONE >>> 1);
    queue_req(vec3au_pkg::OP_DOT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
              COMP_MAX, '0);
    queue_req(vec3au_pkg::OP_DOT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MAX, COMP_MAX,
              COMP_MAX, '0);
    queue_req(vec3au_pkg::OP_DOT, ONE, ONE << 1, -ONE, ONE, ONE, ONE, '0);
    queue_req(vec3au_pkg::OP_CROSS, ONE, '0, '0, '0, ONE, '0, '0);
    queue_req(vec3au_pkg::OP_CROSS, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX,
              COMP_MIN, '0);
    queue_req(vec3au_pkg::OP_MAG, COMP_MIN, COMP_MIN, COMP_MIN, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_MAG, ONE * 3, ONE * 4, '0, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_MAG, '0, '0, '0, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_MAGSQ, COMP_MAX, '0, '0, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_MAGSQ, ONE, -ONE, ONE, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_NORM, '0, '0, '0, COMP_MAX, COMP_MIN, ONE, COMP_MAX);
    queue_req(vec3au_pkg::OP_NORM, comp_t'(1), '0, '0, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_NORM, COMP_MIN, COMP_MAX, COMP_MIN, '0, '0, '0, '0);
    queue_req(vec3au_pkg::OP_NORM, ONE * 3, -ONE * 4, '0, '0, '0, '0, '0);
    repeat (1200) begin
      op = vec3au_pkg::op_t'($urandom_range(0, 7));
      queue_req(op, random_comp(), random_comp(), random_comp(), random_comp(),
                random_comp(), random_comp(), random_comp());
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("vec3_arithmetic_unit verification clean");
    end else begin
      $display("vec3_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule
